// File: src/apsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants for the all-pairs shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int WEIGHT_BITS = 24;
    localparam int VIDX_BITS   = 6;
    localparam int VCOUNT_BITS = 7;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 7'd64;

    // largest value marks unreachable, finite sums saturate one below it
    localparam logic signed [WEIGHT_BITS-1:0] W_MARK   = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_SAT_HI = W_MARK - 1'b1;
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN    = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_RELAX = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [VIDX_BITS-1:0]          src;
        logic [VIDX_BITS-1:0]          dst;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_request;

    typedef struct packed {
        t_kind                         ack_kind;
        logic signed [WEIGHT_BITS-1:0] distance;
        logic                          reachable;
    } t_result;

endpackage

// File: src/apsp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_mem
// Distance matrix storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module apsp_mem #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr_a,
    input  logic [ADDR_BITS-1:0] i_raddr_b,
    output logic [DATA_BITS-1:0] o_rdata_a,
    output logic [DATA_BITS-1:0] o_rdata_b
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata_a;
    logic [DATA_BITS-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: src/apsp_relax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_relax
// Shared relaxation unit: saturating path sum, registered, then strict
// less-than compare against the current entry.
// ----------------------------------------------------------------------------
module apsp_relax (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [apsp_pkg::WEIGHT_BITS-1:0] i_a,
    input  logic signed [apsp_pkg::WEIGHT_BITS-1:0] i_b,
    input  logic signed [apsp_pkg::WEIGHT_BITS-1:0] i_cur,
    output logic signed [apsp_pkg::WEIGHT_BITS-1:0] o_cand,
    output logic                                  o_better
);

    localparam int W = apsp_pkg::WEIGHT_BITS;

    logic signed [W:0]   sum;
    logic signed [W-1:0] n_cand;
    logic signed [W-1:0] r_cand;

    assign sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};

    always_comb begin
        if (i_a == apsp_pkg::W_MARK || i_b == apsp_pkg::W_MARK) begin
            n_cand = apsp_pkg::W_MARK;
        end else if (sum > $signed({apsp_pkg::W_SAT_HI[W-1], apsp_pkg::W_SAT_HI})) begin
            n_cand = apsp_pkg::W_SAT_HI;
        end else if (sum < $signed({apsp_pkg::W_MIN[W-1], apsp_pkg::W_MIN})) begin
            n_cand = apsp_pkg::W_MIN;
        end else begin
            n_cand = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cand <= n_cand;
        end
    end

    // the marker is the largest value, so it never wins
    assign o_better = r_cand < i_cur;
    assign o_cand   = r_cand;

endmodule

// File: src/all_pairs_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall distance matrix with clear, edge write, relax and read.
// ----------------------------------------------------------------------------
// One request at a time: busy is high while a request is in work and every
// request ends in exactly one result on o_result, strobed by o_result_valid
// for one cycle; the receiver cannot stall it. An edge write leaves busy
// low, a read goes through the registered memory read. A clear sweeps the
// whole matrix one entry a cycle, (2**clog2(MAX_VERTICES))^2 entries (4096
// by default). A relax runs over all (k, i, j) below n, n = min(vertex_count,
// MAX_VERTICES): each (k, i, j) step reads two operands, then the current
// entry, through the one relaxation unit and the two memory read ports, and
// writes back on improvement. Write vertex_count only while busy is low and
// no result is pending.
module all_pairs_shortest_path #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  apsp_pkg::t_request                   i_request,
    input  logic                                 i_cfg_we,
    input  logic [apsp_pkg::VCOUNT_BITS-1:0]     i_cfg_wdata,
    output logic                                 o_result_valid,
    output apsp_pkg::t_result                    o_result
);

    localparam int W  = apsp_pkg::WEIGHT_BITS;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = IW + 1;
    localparam int AW = 2 * IW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_RD_A,
        S_RD_C,
        S_CMP
    } t_state;

    t_state r_state, n_state;
    logic   r_result_valid, n_result_valid;
    apsp_pkg::t_result r_result, n_result;
    logic [apsp_pkg::VCOUNT_BITS-1:0] r_vcount, n_vcount;
    logic [NW-1:0] r_n, n_n;
    logic [IW-1:0] r_k, n_k, r_i, n_i, r_j, n_j;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_rd_ok, n_rd_ok;

    logic          accept;
    logic          in_range;
    logic [IW-1:0] req_src, req_dst;
    logic          last_i, last_j, last_k;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, raddr_a, raddr_b;
    logic [W-1:0]  mem_wdata, rdata_a, rdata_b;

    logic          relax_load;
    logic signed [W-1:0] relax_cand;
    logic          relax_better;

    assign accept   = start && (r_state == S_IDLE);
    assign req_src  = IW'(i_request.src);
    assign req_dst  = IW'(i_request.dst);
    assign in_range = (32'(i_request.src) < 32'(MAX_VERTICES))
                   && (32'(i_request.dst) < 32'(MAX_VERTICES));

    assign last_j = (NW'(r_j) + NW'(1)) == r_n;
    assign last_i = (NW'(r_i) + NW'(1)) == r_n;
    assign last_k = (NW'(r_k) + NW'(1)) == r_n;

    apsp_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign relax_load = (r_state == S_RD_C);

    apsp_relax u_relax (
        .i_clk    (i_clk),
        .i_load   (relax_load),
        .i_a      (rdata_a),
        .i_b      (rdata_b),
        .i_cur    (rdata_a),
        .o_cand   (relax_cand),
        .o_better (relax_better)
    );

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {req_src, req_dst};
        mem_wdata = i_request.weight;
        raddr_a   = {req_src, req_dst};
        raddr_b   = {r_k, r_j};
        case (r_state)
            S_IDLE: begin
                mem_we = accept && (i_request.kind == apsp_pkg::KIND_EDGE) && in_range;
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr[AW-1:IW] == r_clr[IW-1:0]) ? '0 : apsp_pkg::W_MARK;
            end
            S_RD_A: begin
                raddr_a = {r_i, r_k};
                raddr_b = {r_k, r_j};
            end
            S_RD_C: begin
                raddr_a = {r_i, r_j};
            end
            S_CMP: begin
                mem_we    = relax_better;
                mem_waddr = {r_i, r_j};
                mem_wdata = relax_cand;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state        = r_state;
        n_result_valid = 1'b0;
        n_result       = r_result;
        n_vcount       = i_cfg_we ? i_cfg_wdata : r_vcount;
        n_n            = r_n;
        n_k            = r_k;
        n_i            = r_i;
        n_j            = r_j;
        n_clr          = r_clr;
        n_rd_ok        = r_rd_ok;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result.ack_kind  = i_request.kind;
                    n_result.distance  = '0;
                    n_result.reachable = 1'b0;
                    n_rd_ok            = in_range;
                    case (i_request.kind)
                        apsp_pkg::KIND_CLEAR: begin
                            n_clr   = '0;
                            n_state = S_CLEAR;
                        end
                        apsp_pkg::KIND_EDGE: begin
                            n_result_valid = 1'b1;
                        end
                        apsp_pkg::KIND_RELAX: begin
                            n_n = (32'(r_vcount) > 32'(MAX_VERTICES))
                                ? NW'(MAX_VERTICES) : NW'(r_vcount);
                            n_k = '0;
                            n_i = '0;
                            n_j = '0;
                            if (r_vcount == '0) begin
                                n_result_valid = 1'b1;
                            end else begin
                                n_state = S_RD_A;
                            end
                        end
                        apsp_pkg::KIND_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_result_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                if (r_rd_ok) begin
                    n_result.distance  = rdata_a;
                    n_result.reachable = (rdata_a != apsp_pkg::W_MARK);
                end
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            S_RD_A: begin
                n_state = S_RD_C;
            end
            S_RD_C: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_RD_A;
                if (!last_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    if (!last_i) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        n_i = '0;
                        if (!last_k) begin
                            n_k = r_k + 1'b1;
                        end else begin
                            n_result_valid = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_n      <= n_n;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_clr    <= n_clr;
        r_rd_ok  <= n_rd_ok;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
            r_vcount       <= apsp_pkg::VCOUNT_RESET;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
            r_vcount       <= n_vcount;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// File: src/apsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_checker
// Port-level checks for the all-pairs shortest path block, bound to the top.
// ----------------------------------------------------------------------------
module apsp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input apsp_pkg::t_request i_request,
    input logic               o_result_valid,
    input apsp_pkg::t_result  o_result
);

    // only a read carries a distance
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.ack_kind != apsp_pkg::KIND_READ
        |-> o_result.distance == '0 && !o_result.reachable)
        else $error("non-read result carries a distance");

    a_mark_unreachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.reachable
        |-> o_result.distance != apsp_pkg::W_MARK)
        else $error("marker reported as reachable");

    a_edge_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_request.kind == apsp_pkg::KIND_EDGE
        |=> o_result_valid && o_result.ack_kind == apsp_pkg::KIND_EDGE && !busy)
        else $error("edge request not acknowledged next cycle");

    a_read_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_request.kind == apsp_pkg::KIND_READ
        |=> busy ##1 (o_result_valid && o_result.ack_kind == apsp_pkg::KIND_READ))
        else $error("read request not answered after two cycles");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_request      (i_request),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// File: verif/tb_all_pairs_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_all_pairs_shortest_path
// Self-checking bench for the Floyd-Warshall distance matrix block: a queue
// of planned requests and vertex-count writes feeds a clocked driver, a
// shadow matrix predicts every acknowledge, and a clocked monitor checks
// each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_all_pairs_shortest_path;

    localparam int N_MAX        = 64;
    localparam int MARK_VAL     = int'(apsp_pkg::W_MARK);
    localparam int SAT_HI_VAL   = int'(apsp_pkg::W_SAT_HI);
    localparam int MIN_VAL      = int'(apsp_pkg::W_MIN);
    localparam int QUIET_CYCLES = 4;
    localparam int TAIL_CYCLES  = 16;
    localparam int PHASE_ITEMS  = 208;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_CFG,
        ACT_DRAIN
    } t_act_op;

    typedef struct {
        t_act_op                          op;
        apsp_pkg::t_request               req;
        logic [apsp_pkg::VCOUNT_BITS-1:0] cfg;
        int unsigned                      idle_pct;
    } t_action;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    apsp_pkg::t_request               i_request;
    logic                             i_cfg_we;
    logic [apsp_pkg::VCOUNT_BITS-1:0] i_cfg_wdata;
    logic                             o_result_valid;
    apsp_pkg::t_result                o_result;

    t_action           request_plan[$];
    apsp_pkg::t_result expected_acks[$];
    int                shadow_dist[N_MAX*N_MAX];
    int                shadow_vcount;
    int                quiet_cycles;
    int                mismatch_count;
    int                planned_items;

    all_pairs_shortest_path #(
        .MAX_VERTICES (N_MAX)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #40_000_000;
        $display("timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // shadow matrix
    // ------------------------------------------------------------------------
    // marker is absorbing, finite sums clip one below the marker
    function automatic int sat_path_sum(int a, int b);
        int s;
        if (a == MARK_VAL || b == MARK_VAL)
            return MARK_VAL;
        s = a + b;
        if (s > SAT_HI_VAL)
            s = SAT_HI_VAL;
        if (s < MIN_VAL)
            s = MIN_VAL;
        return s;
    endfunction

    function automatic apsp_pkg::t_result apply_request(apsp_pkg::t_request req);
        apsp_pkg::t_result res;
        int      n;
        int      k;
        int      i;
        int      j;
        int      cand;
        int      d;
        res          = '0;
        res.ack_kind = req.kind;
        case (req.kind)
            apsp_pkg::KIND_CLEAR: begin
                for (i = 0; i < N_MAX*N_MAX; i++)
                    shadow_dist[i] = MARK_VAL;
                for (i = 0; i < N_MAX; i++)
                    shadow_dist[i*N_MAX + i] = 0;
            end
            apsp_pkg::KIND_EDGE: begin
                shadow_dist[int'(req.src)*N_MAX + int'(req.dst)] = int'($signed(req.weight));
            end
            apsp_pkg::KIND_RELAX: begin
                n = (shadow_vcount > N_MAX) ? N_MAX : shadow_vcount;
                for (k = 0; k < n; k++)
                    for (i = 0; i < n; i++)
                        for (j = 0; j < n; j++) begin
                            cand = sat_path_sum(shadow_dist[i*N_MAX + k],
                                                shadow_dist[k*N_MAX + j]);
                            if (cand < shadow_dist[i*N_MAX + j])
                                shadow_dist[i*N_MAX + j] = cand;
                        end
            end
            default: begin
                d             = shadow_dist[int'(req.src)*N_MAX + int'(req.dst)];
                res.distance  = d[apsp_pkg::WEIGHT_BITS-1:0];
                res.reachable = (d != MARK_VAL);
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // plan building
    // ------------------------------------------------------------------------
    task automatic push_request(apsp_pkg::t_kind kind, int src, int dst, int weight,
                                int unsigned idle);
        t_action act;
        act.op         = ACT_REQ;
        act.req.kind   = kind;
        act.req.src    = src[apsp_pkg::VIDX_BITS-1:0];
        act.req.dst    = dst[apsp_pkg::VIDX_BITS-1:0];
        act.req.weight = weight[apsp_pkg::WEIGHT_BITS-1:0];
        act.cfg        = '0;
        act.idle_pct   = idle;
        request_plan.push_back(act);
        planned_items++;
    endtask

    task automatic push_ctrl(t_act_op op, int value);
        t_action act;
        act.op       = op;
        act.req      = '0;
        act.cfg      = value[apsp_pkg::VCOUNT_BITS-1:0];
        act.idle_pct = 0;
        request_plan.push_back(act);
    endtask

    function automatic int pick_weight();
        logic [31:0]                            rnd;
        logic signed [apsp_pkg::WEIGHT_BITS-1:0] raw;
        rnd = $urandom;
        raw = rnd[apsp_pkg::WEIGHT_BITS-1:0];
        case ($urandom_range(9))
            0, 1, 2, 3: return int'($urandom_range(4096));
            4:          return int'($urandom_range(600)) - 100;
            5:          return int'(raw);
            6:          return MARK_VAL;
            7:          return SAT_HI_VAL - int'($urandom_range(65536));
            8:          return MIN_VAL + int'($urandom_range(3));
            default:    return int'($urandom_range(SAT_HI_VAL));
        endcase
    endfunction

    function automatic int pick_vertex(int span);
        if ($urandom_range(99) < 85)
            return int'($urandom_range(span - 1));
        return int'($urandom_range(N_MAX - 1));
    endfunction

    // one graph round: optional clear, edges, relax, reads, a little noise
    task automatic push_round(int vcount, int unsigned idle);
        int span;
        int count;
        int e;
        span = (vcount == 0) ? 1 : ((vcount > N_MAX) ? N_MAX : vcount);
        if ($urandom_range(99) < 30)
            push_request(apsp_pkg::KIND_CLEAR, $urandom, $urandom, $urandom, idle);
        count = $urandom_range(3*span + 2, 1);
        for (e = 0; e < count; e++) begin
            if ($urandom_range(99) < 10)
                push_request(apsp_pkg::t_kind'($urandom_range(3, 1)), $urandom, $urandom,
                             $urandom, idle);
            else
                push_request(apsp_pkg::KIND_EDGE, pick_vertex(span), pick_vertex(span),
                             pick_weight(), idle);
        end
        if ($urandom_range(99) < 10)
            push_ctrl(ACT_DRAIN, 0);
        push_request(apsp_pkg::KIND_RELAX, $urandom, $urandom, $urandom, idle);
        count = $urandom_range(2*span + 2, 2);
        for (e = 0; e < count; e++)
            push_request(apsp_pkg::KIND_READ, pick_vertex(span), pick_vertex(span),
                         $urandom, idle);
    endtask

    task automatic build_plan();
        int          vcounts[8] = '{5, 8, 1, 3, 0, 6, 2, 7};
        int unsigned idles[4]   = '{0, 45, 0, 13};
        int          p;
        int          e;
        int          phase_start;

        // directed: extremes, saturation both ways, marker, diagonal, far entries
        push_ctrl(ACT_CFG, 4);
        push_request(apsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 63, 0, 0);
        push_request(apsp_pkg::KIND_EDGE, 0, 1, SAT_HI_VAL, 0);
        push_request(apsp_pkg::KIND_EDGE, 1, 2, SAT_HI_VAL, 0);
        push_request(apsp_pkg::KIND_EDGE, 2, 3, MIN_VAL, 0);
        push_request(apsp_pkg::KIND_EDGE, 3, 0, MARK_VAL, 0);
        push_request(apsp_pkg::KIND_EDGE, 2, 2, 5, 0);
        push_request(apsp_pkg::KIND_EDGE, 63, 63, -1, 0);
        push_request(apsp_pkg::KIND_EDGE, 10, 5, 256, 0);
        push_request(apsp_pkg::KIND_RELAX, 0, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 2, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 3, 0, 0);
        push_request(apsp_pkg::KIND_READ, 1, 3, 0, 0);
        push_request(apsp_pkg::KIND_READ, 3, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 2, 2, 0, 0);
        push_request(apsp_pkg::KIND_READ, 63, 63, 0, 0);
        push_request(apsp_pkg::KIND_READ, 10, 5, 0, 0);
        // zero vertices: relax leaves the matrix alone
        push_ctrl(ACT_CFG, 0);
        push_request(apsp_pkg::KIND_RELAX, 63, 63, MARK_VAL, 0);
        push_request(apsp_pkg::KIND_READ, 0, 3, 0, 0);
        // negative self loop doubles down to the low clip
        push_request(apsp_pkg::KIND_EDGE, 0, 0, MIN_VAL + 3, 0);
        push_ctrl(ACT_CFG, 1);
        push_request(apsp_pkg::KIND_RELAX, 0, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 0, 0, 0);

        for (p = 0; p < 8; p++) begin
            push_ctrl(ACT_CFG, vcounts[p]);
            phase_start = planned_items;
            while (planned_items - phase_start < PHASE_ITEMS)
                push_round(vcounts[p], idles[p % 4]);
        end

        // one full-size relax, count above the matrix size
        push_ctrl(ACT_CFG, 127);
        push_request(apsp_pkg::KIND_CLEAR, 0, 0, 0, 0);
        for (e = 0; e < 40; e++)
            push_request(apsp_pkg::KIND_EDGE, $urandom_range(N_MAX - 1),
                         $urandom_range(N_MAX - 1),
                         ($urandom_range(9) == 0) ? pick_weight() : $urandom_range(4096), 0);
        push_request(apsp_pkg::KIND_EDGE, 0, N_MAX - 1, 1000, 0);
        push_request(apsp_pkg::KIND_EDGE, N_MAX - 1, 1, 2000, 0);
        push_request(apsp_pkg::KIND_RELAX, 0, 0, 0, 0);
        push_request(apsp_pkg::KIND_READ, 0, 1, 0, 0);
        push_request(apsp_pkg::KIND_READ, N_MAX - 1, 0, 0, 0);
        for (e = 0; e < 30; e++)
            push_request(apsp_pkg::KIND_READ, $urandom_range(N_MAX - 1),
                         $urandom_range(N_MAX - 1), $urandom, 13);
    endtask

    initial begin : plan_proc
        planned_items = 0;
        shadow_vcount = int'(apsp_pkg::VCOUNT_RESET);
        foreach (shadow_dist[i])
            shadow_dist[i] = 0;
        build_plan();
        do
            @(posedge i_clk);
        while (request_plan.size() != 0 || start || expected_acks.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_acks.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        logic    nxt_start;
        logic    nxt_we;
        logic    launched;
        t_action act;
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_request    <= '0;
            i_cfg_we     <= 1'b0;
            i_cfg_wdata  <= '0;
            quiet_cycles <= 0;
        end else begin
            launched = start && !busy;
            if (launched)
                expected_acks.push_back(apply_request(i_request));
            nxt_start = start && !launched;
            nxt_we    = 1'b0;
            quiet_cycles <= (!start && !busy && expected_acks.size() == 0) ?
                            quiet_cycles + 1 : 0;
            if (!nxt_start && request_plan.size() != 0) begin
                act = request_plan[0];
                if (act.op == ACT_REQ) begin
                    if ($urandom_range(99) >= act.idle_pct) begin
                        i_request <= act.req;
                        nxt_start = 1'b1;
                        void'(request_plan.pop_front());
                    end
                end else if (quiet_cycles >= QUIET_CYCLES) begin
                    // register writes and drains only once the block is idle
                    if (act.op == ACT_CFG) begin
                        nxt_we = 1'b1;
                        i_cfg_wdata <= act.cfg;
                        shadow_vcount = int'(act.cfg);
                    end
                    void'(request_plan.pop_front());
                end
            end
            start    <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor_proc
        apsp_pkg::t_result want;
        if (i_rst_n && o_result_valid) begin
            if (expected_acks.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual kind=%0d %s%0d %s%0b",
                         $time, o_result.ack_kind, "dist=", o_result.distance,
                         "reach=", o_result.reachable);
            end else begin
                want = expected_acks.pop_front();
                if (o_result.ack_kind !== want.ack_kind ||
                    o_result.distance !== want.distance ||
                    o_result.reachable !== want.reachable) begin
                    mismatch_count++;
                    $display("%0t: mismatch expected kind=%0d dist=%0d reach=%0b, %s%0d %s%0d %s%0b",
                             $time, want.ack_kind, want.distance, want.reachable,
                             "actual kind=", o_result.ack_kind,
                             "dist=", o_result.distance,
                             "reach=", o_result.reachable);
                end
            end
        end
    end

endmodule
